### sv/brm_pkg.sv
// Shared types and codes for the byte register machine executor.
// No dependencies; every other file but the two channel interfaces imports this package.
package brm_pkg;

    typedef logic [7:0] t_byte;

    // Host command codes
    localparam logic [2:0] CMD_EXEC   = 3'd0;
    localparam logic [2:0] CMD_WR_REG = 3'd1;
    localparam logic [2:0] CMD_WR_MEM = 3'd2;
    localparam logic [2:0] CMD_RD_REG = 3'd3;
    localparam logic [2:0] CMD_RD_MEM = 3'd4;

    // Instruction opcodes
    localparam logic [7:0] OPC_AND   = 8'd0;
    localparam logic [7:0] OPC_OR    = 8'd1;
    localparam logic [7:0] OPC_ADD   = 8'd2;
    localparam logic [7:0] OPC_MUL   = 8'd3;
    localparam logic [7:0] OPC_XOR   = 8'd4;
    localparam logic [7:0] OPC_OUT   = 8'd5;
    localparam logic [7:0] OPC_SLEEP = 8'd6;
    localparam logic [7:0] OPC_LOAD  = 8'd7;
    localparam logic [7:0] OPC_STORE = 8'd8;
    localparam logic [7:0] OPC_BNE   = 8'd9;
    localparam logic [7:0] OPC_LDI   = 8'd10;
    localparam logic [7:0] OPC_STI   = 8'd11;

    // Result kinds
    localparam logic [2:0] KIND_DONE   = 3'd0;
    localparam logic [2:0] KIND_OUT    = 3'd1;
    localparam logic [2:0] KIND_SLEEP  = 3'd2;
    localparam logic [2:0] KIND_BRANCH = 3'd3;
    localparam logic [2:0] KIND_READ   = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // Configuration port
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 10;
    localparam logic [0:0] CFG_REGS_IN_USE = 1'd0;
    localparam logic [0:0] CFG_MEM_IN_USE  = 1'd1;
    localparam logic [5:0] CFG_REGS_RESET  = 6'd32;
    localparam logic [9:0] CFG_MEM_RESET   = 10'd512;

    // Limit widths cover the largest register file and memory depths
    localparam int REG_LIM_W = 9;
    localparam int MEM_LIM_W = 13;

    // One input item
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] opcode;
        logic [7:0] first_operand;
        logic [7:0] second_operand;
        logic [7:0] third_operand;
        logic [8:0] host_address;
        logic [7:0] host_data;
    } t_in_item;

    // Decoded result and side effects of one item
    typedef struct packed {
        logic [2:0] kind;
        t_byte      value;
        t_byte      target;
        logic       use_mem;
        logic       reg_we;
        logic       reg_load;
        t_byte      reg_wdata;
        logic       mem_we;
        t_byte      mem_wdata;
    } t_exec_ctl;

endpackage

### sv/brm_in_if.sv
// Input channel of the byte register machine executor: valid/ready plus item fields.
// No dependencies.
interface brm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] opcode;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
    logic [7:0] third_operand;
    logic [8:0] host_address;
    logic [7:0] host_data;

    modport source (
        output valid, command, opcode, first_operand, second_operand,
               third_operand, host_address, host_data,
        input  ready
    );

    modport sink (
        input  valid, command, opcode, first_operand, second_operand,
               third_operand, host_address, host_data,
        output ready
    );
endinterface

### sv/brm_out_if.sv
// Result channel of the byte register machine executor: valid/ready plus result fields.
// No dependencies.
interface brm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] branch_target;

    modport source (
        output valid, kind, value, branch_target,
        input  ready
    );

    modport sink (
        input  valid, kind, value, branch_target,
        output ready
    );
endinterface

### sv/brm_regfile.sv
// Register file: one write port, two registered read ports, per-entry valid bits.
// Depends on brm_pkg. An entry never written since reset reads as zero.
module brm_regfile #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr_x,
    input  logic [AW-1:0]        i_rd_addr_y,
    output brm_pkg::t_byte       o_rd_data_x,
    output brm_pkg::t_byte       o_rd_data_y,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  brm_pkg::t_byte       i_wr_data
);
    import brm_pkg::*;

    t_byte            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_byte            r_rd_x;
    t_byte            r_rd_y;
    logic             r_rd_vx;
    logic             r_rd_vy;

    // Storage array and registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_x <= r_mem[i_rd_addr_x];
            r_rd_y <= r_mem[i_rd_addr_y];
        end
    end

    // Valid bits: clear on reset, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_vx <= 1'b0;
            r_rd_vy <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vx <= r_valid[i_rd_addr_x];
                r_rd_vy <= r_valid[i_rd_addr_y];
            end
        end
    end

    // Unwritten entries read as zero
    assign o_rd_data_x = r_rd_vx ? r_rd_x : '0;
    assign o_rd_data_y = r_rd_vy ? r_rd_y : '0;

endmodule

### sv/brm_datamem.sv
// Data memory: one write port, one registered read port, zeroing sweep after reset.
// Depends on brm_pkg. o_busy stays high while the sweep runs.
module brm_datamem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    output logic           o_busy,
    input  logic           i_rd_en,
    input  logic [AW-1:0]  i_rd_addr,
    output brm_pkg::t_byte o_rd_data,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  brm_pkg::t_byte i_wr_data
);
    import brm_pkg::*;

    t_byte         r_mem [DEPTH];
    t_byte         r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          n_we;
    logic [AW-1:0] n_waddr;
    t_byte         n_wdata;

    // Step through every entry once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Sweep owns the write port while it runs
    always_comb begin
        n_we    = r_clr_busy | i_wr_en;
        n_waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
        n_wdata = r_clr_busy ? '0 : i_wr_data;
    end

    // Storage array and registered read data
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy    = r_clr_busy;
    assign o_rd_data = r_rd_data;

endmodule

### sv/brm_exec.sv
// Execute stage: range checks, ALU and result decode for one item.
// Depends on brm_pkg. Operands arrive already forwarded; purely combinational.
module brm_exec #(
    parameter int RW = 5,
    parameter int MW = 9
) (
    input  brm_pkg::t_in_item                  i_item,
    input  brm_pkg::t_byte                     i_x,
    input  brm_pkg::t_byte                     i_y,
    input  logic [brm_pkg::REG_LIM_W-1:0]      i_reg_limit,
    input  logic [brm_pkg::MEM_LIM_W-1:0]      i_mem_limit,
    output brm_pkg::t_exec_ctl                 o_ctl,
    output logic [RW-1:0]                      o_reg_widx,
    output logic [MW-1:0]                      o_mem_addr
);
    import brm_pkg::*;

    t_byte       alu;
    logic [15:0] prod;
    logic        ok_a;
    logic        ok_b;
    logic        ok_c;
    logic        ok_h;
    logic        ok_hm;
    logic        ok_xm;
    logic        err;
    t_exec_ctl   ctl;

    // Index and address range checks against the active limits
    always_comb begin
        ok_a  = REG_LIM_W'(i_item.first_operand)  < i_reg_limit;
        ok_b  = REG_LIM_W'(i_item.second_operand) < i_reg_limit;
        ok_c  = REG_LIM_W'(i_item.third_operand)  < i_reg_limit;
        ok_h  = REG_LIM_W'(i_item.host_address)   < i_reg_limit;
        ok_hm = MEM_LIM_W'(i_item.host_address)   < i_mem_limit;
        ok_xm = MEM_LIM_W'(i_x)                   < i_mem_limit;
    end

    // Byte ALU, wraps modulo 256
    assign prod = i_x * i_y;
    always_comb begin
        unique case (i_item.opcode)
            OPC_AND: alu = i_x & i_y;
            OPC_OR:  alu = i_x | i_y;
            OPC_ADD: alu = i_x + i_y;
            OPC_MUL: alu = prod[7:0];
            default: alu = i_x ^ i_y;
        endcase
    end

    // Decode the item into its result and store updates
    always_comb begin
        ctl      = '0;
        ctl.kind = KIND_DONE;
        err      = 1'b0;
        unique case (i_item.command)
            CMD_EXEC: begin
                unique case (i_item.opcode)
                    OPC_AND, OPC_OR, OPC_ADD, OPC_MUL, OPC_XOR: begin
                        err           = !(ok_a && ok_b && ok_c);
                        ctl.reg_we    = 1'b1;
                        ctl.reg_wdata = alu;
                    end
                    OPC_OUT: begin
                        err       = !ok_a;
                        ctl.kind  = KIND_OUT;
                        ctl.value = i_x;
                    end
                    OPC_SLEEP: begin
                        err       = !ok_a;
                        ctl.kind  = KIND_SLEEP;
                        ctl.value = i_x;
                    end
                    OPC_LOAD: begin
                        err          = !(ok_a && ok_b && ok_xm);
                        ctl.reg_we   = 1'b1;
                        ctl.reg_load = 1'b1;
                    end
                    OPC_STORE: begin
                        err           = !(ok_a && ok_b && ok_xm);
                        ctl.mem_we    = 1'b1;
                        ctl.mem_wdata = i_y;
                    end
                    OPC_BNE: begin
                        err = !(ok_a && ok_b);
                        if (i_x != i_y) begin
                            ctl.kind   = KIND_BRANCH;
                            ctl.target = i_item.third_operand;
                        end
                    end
                    OPC_LDI: begin
                        err           = !ok_a;
                        ctl.reg_we    = 1'b1;
                        ctl.reg_wdata = i_item.second_operand;
                    end
                    OPC_STI: begin
                        err           = !(ok_a && ok_xm);
                        ctl.mem_we    = 1'b1;
                        ctl.mem_wdata = i_item.second_operand;
                    end
                    default: err = 1'b1;
                endcase
            end
            CMD_WR_REG: begin
                err           = !ok_h;
                ctl.reg_we    = 1'b1;
                ctl.reg_wdata = i_item.host_data;
            end
            CMD_WR_MEM: begin
                err           = !ok_hm;
                ctl.mem_we    = 1'b1;
                ctl.mem_wdata = i_item.host_data;
            end
            CMD_RD_REG: begin
                err       = !ok_h;
                ctl.kind  = KIND_READ;
                ctl.value = i_x;
            end
            CMD_RD_MEM: begin
                err         = !ok_hm;
                ctl.kind    = KIND_READ;
                ctl.use_mem = 1'b1;
            end
            default: err = 1'b1;
        endcase

        // A fault drops every side effect
        if (err) begin
            ctl      = '0;
            ctl.kind = KIND_ERROR;
        end
        o_ctl = ctl;
    end

    // Write index and memory address
    always_comb begin
        if (i_item.command == CMD_WR_REG) begin
            o_reg_widx = i_item.host_address[RW-1:0];
        end else begin
            o_reg_widx = i_item.first_operand[RW-1:0];
        end
        if (i_item.command == CMD_WR_MEM || i_item.command == CMD_RD_MEM) begin
            o_mem_addr = MW'(i_item.host_address);
        end else begin
            o_mem_addr = MW'(i_x);
        end
    end

endmodule

### sv/byte_register_machine_executor.sv
// Byte register machine executor: one 4-byte instruction or host command per item.
// The input transfer loads the execute-stage register, then the result register; one item
// per cycle while the result channel does not stall, back-to-back dependences forwarded.
// Reset: registers read as zero at once; the data memory is zeroed by a sweep over all
// MEM_DEPTH entries; no item is accepted meanwhile. Write config with nothing in flight.
module byte_register_machine_executor #(
    parameter int REG_DEPTH = 32,
    parameter int MEM_DEPTH = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [brm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [brm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    brm_in_if.sink                            i_in,
    brm_out_if.source                         o_out
);
    import brm_pkg::*;

    localparam int RW = $clog2(REG_DEPTH);
    localparam int MW = $clog2(MEM_DEPTH);

    // Configuration
    logic [5:0]           r_regs_in_use;
    logic [9:0]           r_mem_in_use;
    logic [REG_LIM_W-1:0] reg_limit;
    logic [MEM_LIM_W-1:0] mem_limit;

    // Input side
    t_in_item             in_item;
    logic                 in_xfer;
    logic                 out_xfer;
    logic [RW-1:0]        rd_x_idx;
    logic [RW-1:0]        rd_y_idx;

    // Execute stage
    logic                 r_b_valid;
    t_in_item             r_b_item;
    logic [RW-1:0]        r_b_x_idx;
    logic [RW-1:0]        r_b_y_idx;
    logic                 r_wb_valid;
    logic [RW-1:0]        r_wb_idx;
    t_byte                r_wb_data;
    logic                 b_adv;
    t_byte                rf_x;
    t_byte                rf_y;
    t_byte                op_x;
    t_byte                op_y;
    t_exec_ctl            ctl;
    logic [RW-1:0]        ctl_reg_widx;
    logic [MW-1:0]        ctl_mem_addr;

    // Result stage
    logic                 r_c_valid;
    logic [2:0]           r_c_kind;
    t_byte                r_c_value;
    t_byte                r_c_target;
    logic                 r_c_use_mem;
    logic                 r_c_reg_we;
    logic                 r_c_reg_load;
    logic [RW-1:0]        r_c_reg_idx;
    t_byte                r_c_reg_data;
    t_byte                c_wdata;
    logic                 rf_we;

    // Memory
    logic                 mem_busy;
    t_byte                mem_rd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs_in_use <= CFG_REGS_RESET;
            r_mem_in_use  <= CFG_MEM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REGS_IN_USE: r_regs_in_use <= i_cfg_data[5:0];
                CFG_MEM_IN_USE:  r_mem_in_use  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Effective limits, capped at the store depths
    always_comb begin
        if (REG_LIM_W'(r_regs_in_use) < REG_LIM_W'(REG_DEPTH)) begin
            reg_limit = REG_LIM_W'(r_regs_in_use);
        end else begin
            reg_limit = REG_LIM_W'(REG_DEPTH);
        end
        if (MEM_LIM_W'(r_mem_in_use) < MEM_LIM_W'(MEM_DEPTH)) begin
            mem_limit = MEM_LIM_W'(r_mem_in_use);
        end else begin
            mem_limit = MEM_LIM_W'(MEM_DEPTH);
        end
    end

    // Gather the input item
    always_comb begin
        in_item.command        = i_in.command;
        in_item.opcode         = i_in.opcode;
        in_item.first_operand  = i_in.first_operand;
        in_item.second_operand = i_in.second_operand;
        in_item.third_operand  = i_in.third_operand;
        in_item.host_address   = i_in.host_address;
        in_item.host_data      = i_in.host_data;
    end

    // Handshakes
    assign out_xfer   = r_c_valid && o_out.ready;
    assign b_adv      = r_b_valid && (!r_c_valid || o_out.ready);
    assign i_in.ready = !mem_busy && (!r_b_valid || b_adv);
    assign in_xfer    = i_in.valid && i_in.ready;

    // Register read addresses for the two ports
    always_comb begin
        rd_x_idx = in_item.first_operand[RW-1:0];
        rd_y_idx = in_item.second_operand[RW-1:0];
        if (in_item.command != CMD_EXEC) begin
            rd_x_idx = in_item.host_address[RW-1:0];
        end else begin
            unique case (in_item.opcode)
                OPC_AND, OPC_OR, OPC_ADD, OPC_MUL, OPC_XOR: begin
                    rd_x_idx = in_item.second_operand[RW-1:0];
                    rd_y_idx = in_item.third_operand[RW-1:0];
                end
                OPC_LOAD: rd_x_idx = in_item.second_operand[RW-1:0];
                OPC_STORE: begin
                    rd_x_idx = in_item.second_operand[RW-1:0];
                    rd_y_idx = in_item.first_operand[RW-1:0];
                end
                default: ;
            endcase
        end
    end

    // Register file, written when a result is transferred out
    assign c_wdata = r_c_reg_load ? mem_rd : r_c_reg_data;
    assign rf_we   = out_xfer && r_c_reg_we;

    brm_regfile #(
        .DEPTH (REG_DEPTH),
        .AW    (RW)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_xfer),
        .i_rd_addr_x (rd_x_idx),
        .i_rd_addr_y (rd_y_idx),
        .o_rd_data_x (rf_x),
        .o_rd_data_y (rf_y),
        .i_wr_en     (rf_we),
        .i_wr_addr   (r_c_reg_idx),
        .i_wr_data   (c_wdata)
    );

    // Execute stage valid and the write that landed as the item was read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_b_valid  <= 1'b1;
                r_wb_valid <= rf_we;
            end else if (b_adv) begin
                r_b_valid  <= 1'b0;
            end
        end
    end

    // Execute stage payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_b_item  <= in_item;
            r_b_x_idx <= rd_x_idx;
            r_b_y_idx <= rd_y_idx;
            r_wb_idx  <= r_c_reg_idx;
            r_wb_data <= c_wdata;
        end
    end

    // Forward the pending result first, then the write made at read time
    always_comb begin
        if (r_c_valid && r_c_reg_we && r_c_reg_idx == r_b_x_idx) begin
            op_x = c_wdata;
        end else if (r_wb_valid && r_wb_idx == r_b_x_idx) begin
            op_x = r_wb_data;
        end else begin
            op_x = rf_x;
        end
        if (r_c_valid && r_c_reg_we && r_c_reg_idx == r_b_y_idx) begin
            op_y = c_wdata;
        end else if (r_wb_valid && r_wb_idx == r_b_y_idx) begin
            op_y = r_wb_data;
        end else begin
            op_y = rf_y;
        end
    end

    brm_exec #(
        .RW (RW),
        .MW (MW)
    ) u_exec (
        .i_item      (r_b_item),
        .i_x         (op_x),
        .i_y         (op_y),
        .i_reg_limit (reg_limit),
        .i_mem_limit (mem_limit),
        .o_ctl       (ctl),
        .o_reg_widx  (ctl_reg_widx),
        .o_mem_addr  (ctl_mem_addr)
    );

    // Data memory: read and write as the item leaves the execute stage
    brm_datamem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MW)
    ) u_datamem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (mem_busy),
        .i_rd_en   (b_adv),
        .i_rd_addr (ctl_mem_addr),
        .o_rd_data (mem_rd),
        .i_wr_en   (b_adv && ctl.mem_we),
        .i_wr_addr (ctl_mem_addr),
        .i_wr_data (ctl.mem_wdata)
    );

    // Result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_adv) begin
            r_c_valid <= 1'b1;
        end else if (out_xfer) begin
            r_c_valid <= 1'b0;
        end
    end

    // Result stage payload
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_c_kind     <= ctl.kind;
            r_c_value    <= ctl.value;
            r_c_target   <= ctl.target;
            r_c_use_mem  <= ctl.use_mem;
            r_c_reg_we   <= ctl.reg_we;
            r_c_reg_load <= ctl.reg_load;
            r_c_reg_idx  <= ctl_reg_widx;
            r_c_reg_data <= ctl.reg_wdata;
        end
    end

    // Drive the result channel
    assign o_out.valid         = r_c_valid;
    assign o_out.kind          = r_c_kind;
    assign o_out.value         = r_c_use_mem ? mem_rd : r_c_value;
    assign o_out.branch_target = r_c_target;

endmodule

### bench/byte_register_machine_executor_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_register_machine_executor: a directed table, then random
// instruction and host traffic under several limits, checked against a model or typed rows.
// Depends on brm_pkg, brm_in_if, brm_out_if and the executor RTL.
module byte_register_machine_executor_test;
    import brm_pkg::*;

    localparam int REG_DEPTH = 32;
    localparam int MEM_DEPTH = 512;
    localparam int DRAIN_LIMIT = 100000;
    localparam int NUM_PHASES = 6;

    // Codes outside the legal sets
    localparam logic [2:0] CMD_BAD_FIRST = CMD_RD_MEM + 3'd1;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
    localparam logic [7:0] OPC_BAD_FIRST = OPC_STI + 8'd1;
    localparam logic [7:0] OPC_BAD_LAST  = 8'hFF;

    // Per-phase limits, item counts and idling (sender idle %, receiver stall %)
    localparam int PHASE_REGS [NUM_PHASES]       = '{32, 1, 63, 0, 20, 32};
    localparam int PHASE_MEM [NUM_PHASES]        = '{512, 1, 1023, 0, 256, 512};
    localparam int PHASE_ITEMS [NUM_PHASES]      = '{280, 240, 260, 60, 300, 385};
    localparam int PHASE_SEND_IDLE [NUM_PHASES]  = '{27, 27, 57, 57, 0, 0};
    localparam int PHASE_RECV_STALL [NUM_PHASES] = '{57, 57, 27, 27, 0, 0};

    typedef struct packed {
        logic [2:0] kind;
        t_byte      value;
        t_byte      target;
    } t_machine_result;

    typedef struct packed {
        t_in_item        item;
        logic            typed;
        t_machine_result want;
    } t_directed_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    brm_in_if  in_if ();
    brm_out_if out_if ();

    byte_register_machine_executor #(
        .REG_DEPTH(REG_DEPTH),
        .MEM_DEPTH(MEM_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Machine image kept by the bench
    t_byte       reg_image [REG_DEPTH];
    t_byte       mem_image [MEM_DEPTH];
    int unsigned regs_in_use;
    int unsigned mem_in_use;

    t_machine_result pending_results [$];
    logic            row_typed;
    t_machine_result row_want;

    int mismatch_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int kind_count [8];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned reg_limit();
        return (regs_in_use < REG_DEPTH) ? regs_in_use : REG_DEPTH;
    endfunction

    function automatic int unsigned mem_limit();
        return (mem_in_use < MEM_DEPTH) ? mem_in_use : MEM_DEPTH;
    endfunction

    // Apply one item to the image and return the result it must produce
    function automatic t_machine_result execute_item(input t_in_item it);
        t_machine_result res;
        int unsigned rl;
        int unsigned ml;
        t_byte x;
        t_byte y;
        t_byte addr;
        res = '{kind: KIND_ERROR, value: 8'd0, target: 8'd0};
        rl = reg_limit();
        ml = mem_limit();
        case (it.command)
            CMD_EXEC: begin
                case (it.opcode)
                    OPC_AND, OPC_OR, OPC_ADD, OPC_MUL, OPC_XOR: begin
                        if (it.first_operand < rl && it.second_operand < rl
                                && it.third_operand < rl) begin
                            x = reg_image[it.second_operand];
                            y = reg_image[it.third_operand];
                            case (it.opcode)
                                OPC_AND: x = x & y;
                                OPC_OR:  x = x | y;
                                OPC_ADD: x = x + y;
                                OPC_MUL: x = x * y;
                                default: x = x ^ y;
                            endcase
                            reg_image[it.first_operand] = x;
                            res.kind = KIND_DONE;
                        end
                    end
                    OPC_OUT, OPC_SLEEP: begin
                        if (it.first_operand < rl) begin
                            res.kind = (it.opcode == OPC_OUT) ? KIND_OUT : KIND_SLEEP;
                            res.value = reg_image[it.first_operand];
                        end
                    end
                    OPC_LOAD, OPC_STORE: begin
                        if (it.first_operand < rl && it.second_operand < rl) begin
                            addr = reg_image[it.second_operand];
                            if (addr < ml) begin
                                if (it.opcode == OPC_LOAD)
                                    reg_image[it.first_operand] = mem_image[addr];
                                else
                                    mem_image[addr] = reg_image[it.first_operand];
                                res.kind = KIND_DONE;
                            end
                        end
                    end
                    OPC_BNE: begin
                        if (it.first_operand < rl && it.second_operand < rl) begin
                            if (reg_image[it.first_operand] != reg_image[it.second_operand]) begin
                                res.kind = KIND_BRANCH;
                                res.target = it.third_operand;
                            end else begin
                                res.kind = KIND_DONE;
                            end
                        end
                    end
                    OPC_LDI: begin
                        if (it.first_operand < rl) begin
                            reg_image[it.first_operand] = it.second_operand;
                            res.kind = KIND_DONE;
                        end
                    end
                    OPC_STI: begin
                        if (it.first_operand < rl) begin
                            addr = reg_image[it.first_operand];
                            if (addr < ml) begin
                                mem_image[addr] = it.second_operand;
                                res.kind = KIND_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_WR_REG: begin
                if (it.host_address < rl) begin
                    reg_image[it.host_address] = it.host_data;
                    res.kind = KIND_DONE;
                end
            end
            CMD_WR_MEM: begin
                if (it.host_address < ml) begin
                    mem_image[it.host_address] = it.host_data;
                    res.kind = KIND_DONE;
                end
            end
            CMD_RD_REG: begin
                if (it.host_address < rl) begin
                    res.kind = KIND_READ;
                    res.value = reg_image[it.host_address];
                end
            end
            CMD_RD_MEM: begin
                if (it.host_address < ml) begin
                    res.kind = KIND_READ;
                    res.value = mem_image[it.host_address];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Register index: mostly inside the current limit, sometimes anywhere
    function automatic t_byte pick_reg();
        int unsigned rl;
        rl = reg_limit();
        if (rl > 0 && $urandom_range(0, 9) != 0)
            return t_byte'($urandom_range(0, rl - 1));
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Data byte: half the time small enough to be a valid address
    function automatic t_byte pick_byte();
        int unsigned ml;
        int unsigned hi;
        ml = mem_limit();
        hi = (ml > 256) ? 255 : ml - 1;
        if (ml > 0 && $urandom_range(0, 1) != 0)
            return t_byte'($urandom_range(0, hi));
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic logic [8:0] pick_host_addr(input int unsigned lim);
        if (lim > 0 && $urandom_range(0, 99) < 85)
            return 9'($urandom_range(0, lim - 1));
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.command = CMD_EXEC;
        else if (pick < 65)
            it.command = CMD_WR_REG;
        else if (pick < 75)
            it.command = CMD_WR_MEM;
        else if (pick < 84)
            it.command = CMD_RD_REG;
        else if (pick < 93)
            it.command = CMD_RD_MEM;
        else
            it.command = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        if ($urandom_range(0, 99) < 92)
            it.opcode = 8'($urandom_range(0, OPC_STI));
        else
            it.opcode = 8'($urandom());
        it.first_operand = pick_reg();
        if (it.opcode == OPC_LDI || it.opcode == OPC_STI)
            it.second_operand = pick_byte();
        else
            it.second_operand = pick_reg();
        it.third_operand = pick_reg();
        if (it.command == CMD_WR_MEM || it.command == CMD_RD_MEM)
            it.host_address = pick_host_addr(mem_limit());
        else
            it.host_address = pick_host_addr(reg_limit());
        it.host_data = pick_byte();
        return it;
    endfunction

    function automatic t_directed_row row(input logic typed, input logic [2:0] kind,
                                          input int value, input logic [2:0] cmd,
                                          input int opc, a, b, c, haddr, hdata);
        t_directed_row r;
        r.item = '{command: cmd, opcode: 8'(opc), first_operand: 8'(a),
                   second_operand: 8'(b), third_operand: 8'(c),
                   host_address: 9'(haddr), host_data: 8'(hdata)};
        r.typed = typed;
        r.want = '{kind: kind, value: 8'(value), target: 8'd0};
        return r;
    endfunction

    // Present one item after a random gap and hold it until the transfer
    task automatic send_item(input t_in_item it, input logic typed,
                             input t_machine_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.command        <= it.command;
        in_if.opcode         <= it.opcode;
        in_if.first_operand  <= it.first_operand;
        in_if.second_operand <= it.second_operand;
        in_if.third_operand  <= it.third_operand;
        in_if.host_address   <= it.host_address;
        in_if.host_data      <= it.host_data;
        row_typed            <= typed;
        row_want             <= want;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_if.valid <= 1'b0;
        do begin
            @(negedge clk);
            guard++;
        end while (pending_results.size() != 0 && guard < DRAIN_LIMIT);
    endtask

    task automatic write_limits(input int regs, input int mem);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REGS_IN_USE;
        cfg_data  <= CFG_DATA_W'(regs);
        @(negedge clk);
        cfg_index <= CFG_MEM_IN_USE;
        cfg_data  <= CFG_DATA_W'(mem);
        @(negedge clk);
        cfg_we <= 1'b0;
        regs_in_use = regs & 'h3F;
        mem_in_use  = mem & 'h3FF;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls at the rate set for the phase
    initial begin : result_sink
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check result transfers, then predict for the input transfer of the same edge
    always @(posedge clk) begin : transfer_check
        t_machine_result want;
        t_machine_result got;
        t_in_item item;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{kind: out_if.kind, value: out_if.value, target: out_if.branch_target};
                kind_count[got.kind]++;
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                             $time, got.kind, got.value);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("value", want.value, got.value);
                    check_field("branch_target", want.target, got.target);
                end
            end
            if (in_if.valid && in_if.ready) begin
                item = '{command: in_if.command, opcode: in_if.opcode,
                         first_operand: in_if.first_operand,
                         second_operand: in_if.second_operand,
                         third_operand: in_if.third_operand,
                         host_address: in_if.host_address, host_data: in_if.host_data};
                want = execute_item(item);
                if (row_typed)
                    want = row_want;
                pending_results.push_back(want);
                items_sent++;
            end
        end
    end

    initial begin : stimulus
        t_directed_row directed_rows [$];

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_REGS_IN_USE;
        cfg_data             = '0;
        in_if.valid          = 1'b0;
        in_if.command        = CMD_EXEC;
        in_if.opcode         = OPC_AND;
        in_if.first_operand  = '0;
        in_if.second_operand = '0;
        in_if.third_operand  = '0;
        in_if.host_address   = '0;
        in_if.host_data      = '0;
        row_typed            = 1'b0;
        row_want             = '0;
        foreach (reg_image[i]) reg_image[i] = '0;
        foreach (mem_image[i]) mem_image[i] = '0;
        foreach (kind_count[i]) kind_count[i] = 0;
        regs_in_use = CFG_REGS_RESET;
        mem_in_use  = CFG_MEM_RESET;

        // Cleared stores, host access at the edges, then each opcode and the error cases
        directed_rows.push_back(row(1, KIND_READ, 0, CMD_RD_REG, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(1, KIND_READ, 0, CMD_RD_MEM, 0, 0, 0, 0, MEM_DEPTH - 1, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_RD_REG, 0, 0, 0, 0, REG_DEPTH, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_WR_REG, 0, 0, 0, 0, 511, 'hFF));
        directed_rows.push_back(row(1, KIND_DONE, 0, CMD_WR_REG, 0, 0, 0, 0, 0, 'hFF));
        directed_rows.push_back(row(1, KIND_DONE, 0, CMD_WR_REG, 0, 0, 0, 0, REG_DEPTH - 1,
                                    'h80));
        directed_rows.push_back(row(1, KIND_DONE, 0, CMD_WR_MEM, 0, 0, 0, 0, MEM_DEPTH - 1,
                                    'hA5));
        directed_rows.push_back(row(1, KIND_READ, 'hA5, CMD_RD_MEM, 0, 0, 0, 0, MEM_DEPTH - 1,
                                    0));
        directed_rows.push_back(row(1, KIND_DONE, 0, CMD_EXEC, OPC_LDI, 1, 'h7F, 'hFF, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_ADD, 2, 0, 1, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_MUL, 3, 0, 31, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_AND, 4, 0, 1, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_XOR, 5, 0, 31, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_OR, 6, 1, 31, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_OUT, 2, 'hFF, 'hFF, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_SLEEP, 3, 'hFF, 0, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_LDI, 7, 'hC8, 0, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_STI, 7, 'h55, 0, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_LOAD, 8, 7, 0, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_STORE, 1, 8, 0, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_BNE, 0, 1, 'hFF, 0, 0));
        directed_rows.push_back(row(0, KIND_DONE, 0, CMD_EXEC, OPC_BNE, 0, 0, 'h12, 0, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_EXEC, OPC_BAD_FIRST, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_EXEC, OPC_BAD_LAST, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_BAD_LAST, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(1, KIND_ERROR, 0, CMD_EXEC, OPC_ADD, 2, 1, 'hFF, 0, 0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Change limits only with nothing in flight; the first phase keeps reset values
            if (p != 0) begin
                wait_drained();
                write_limits(PHASE_REGS[p], PHASE_MEM[p]);
            end
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            if (p == 0) begin
                foreach (directed_rows[i])
                    send_item(directed_rows[i].item, directed_rows[i].typed,
                              directed_rows[i].want);
            end
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if (p == 0 && n == 140)
                    wait_drained();
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (6) @(negedge clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results missing, expected 0 outstanding, actual %0d",
                     $time, pending_results.size(), pending_results.size());
            mismatch_count++;
        end

        $display("covered %0d transfers in (%0d directed) and %0d out over %0d limit settings",
                 items_sent, directed_rows.size(), results_seen, NUM_PHASES);
        $display("results: done %0d, out %0d, sleep %0d, branch %0d, read %0d, error %0d",
                 kind_count[KIND_DONE], kind_count[KIND_OUT], kind_count[KIND_SLEEP],
                 kind_count[KIND_BRANCH], kind_count[KIND_READ], kind_count[KIND_ERROR]);
        if (mismatch_count == 0) begin
            $display("byte_register_machine_executor_test passed");
        end else begin
            $display("byte_register_machine_executor_test failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("byte_register_machine_executor_test failed");
        $finish;
    end

endmodule

### files.f
sv/brm_pkg.sv
sv/brm_in_if.sv
sv/brm_out_if.sv
sv/brm_regfile.sv
sv/brm_datamem.sv
sv/brm_exec.sv
sv/byte_register_machine_executor.sv
bench/byte_register_machine_executor_test.sv
